// ----- src/bpp_pkg.sv -----
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and constants for the button packet parser
// Byte codes, parser phases, command classes and the queue entry format.
// ----------------------------------------------------------------------------
package bpp_pkg;

  // packet byte codes
  localparam logic [7:0] CH_START  = 8'h21;  // '!'
  localparam logic [7:0] CH_BUTTON = 8'h42;  // 'B'
  localparam logic [7:0] CH_ONE    = 8'h31;  // '1'
  localparam logic [7:0] CH_TWO    = 8'h32;  // '2'
  localparam logic [7:0] CH_THREE  = 8'h33;  // '3'
  localparam logic [7:0] CH_FOUR   = 8'h34;  // '4'

  // default depth of the queue between parser and action stage
  localparam int QUEUE_DEPTH_DEF = 2;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_START = 3'd1,
    PH_TYPE  = 3'd2,
    PH_NUM   = 3'd3,
    PH_HIT   = 3'd4
  } bpp_phase_t;

  // what a good packet asks the action stage to do
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_PREV   = 3'd2,
    CMD_BACK2  = 3'd3,
    CMD_STAY   = 3'd4
  } bpp_cmd_t;

  // one classified packet
  typedef struct packed {
    logic [7:0] button;
    logic       pressed;
    bpp_cmd_t   cmd;
  } bpp_entry_t;

  // classify a packet by its button and hit bytes
  function automatic bpp_cmd_t bpp_classify(input logic [7:0] button,
                                            input logic [7:0] hit);
    bpp_cmd_t c;
    c = CMD_NONE;
    if (hit == CH_ONE) begin
      unique case (button)
        CH_ONE:   c = CMD_TOGGLE;
        CH_TWO:   c = CMD_PREV;
        CH_THREE: c = CMD_BACK2;
        CH_FOUR:  c = CMD_STAY;
        default:  c = CMD_NONE;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- src/bpp_front.sv -----
// ----------------------------------------------------------------------------
// bpp_front: byte parser
// Tracks the five-byte packet pattern, checks the check byte and pushes
// one classified entry per good packet into the queue.
// ----------------------------------------------------------------------------
module bpp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                push_valid,
  input  logic                push_ready,
  output bpp_pkg::bpp_entry_t push_entry
);
  import bpp_pkg::*;

  bpp_phase_t phase, phase_next;
  logic [7:0] held_button;
  logic [7:0] held_hit;
  logic [7:0] sum;
  logic [7:0] check;
  logic       accept;

  // stall only while the queue cannot take an entry
  assign in_stall = !push_ready;
  assign accept   = in_valid && !in_stall;

  // expected check byte
  assign sum   = CH_START + CH_BUTTON + held_button + held_hit;
  assign check = ~sum;

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT:  phase_next = (rx_byte == CH_START) ? PH_START : PH_HUNT;
        PH_START: phase_next = (rx_byte == CH_BUTTON) ? PH_TYPE : PH_HUNT;
        PH_TYPE:  phase_next = PH_NUM;
        PH_NUM:   phase_next = PH_HIT;
        PH_HIT:   phase_next = PH_HUNT;
        default:  phase_next = (rx_byte == CH_START) ? PH_START : PH_HUNT;
      endcase
    end
  end

  // push a good packet
  always_comb begin
    push_valid         = 1'b0;
    push_entry.button  = held_button;
    push_entry.pressed = (held_hit == CH_ONE);
    push_entry.cmd     = bpp_classify(held_button, held_hit);
    unique case (phase)
      PH_HIT:  push_valid = accept && (rx_byte == check);
      default: push_valid = 1'b0;
    endcase
  end

  // phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // held packet bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      held_button <= '0;
      held_hit    <= '0;
    end else if (accept) begin
      if (phase == PH_TYPE) begin
        held_button <= rx_byte;
      end
      if (phase == PH_NUM) begin
        held_hit <= rx_byte;
      end
    end
  end

  // a push only ends a packet, after which the parser hunts again
  a_push_ends_packet: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> phase == PH_HUNT)
    else $error("push did not return parser to hunting");

endmodule

// ----- src/bpp_queue.sv -----
// ----------------------------------------------------------------------------
// bpp_queue: small entry queue
// Decouples the parser from the action stage so that each stalls alone.
// ----------------------------------------------------------------------------
module bpp_queue #(
  parameter int DEPTH = bpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  bpp_pkg::bpp_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bpp_pkg::bpp_entry_t pop_entry
);
  import bpp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  bpp_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  // status toward both sides
  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// ----- src/bpp_back.sv -----
// ----------------------------------------------------------------------------
// bpp_back: action stage
// Pops classified packets, keeps the pause flag and holds each result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module bpp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  bpp_pkg::bpp_entry_t pop_entry,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          button_code,
  output logic                pressed,
  output logic                pause_flag,
  output logic                kill_request,
  output logic signed [1:0]   song_step
);
  import bpp_pkg::*;

  logic              paused;
  logic              paused_next;
  logic              load;
  logic              kill_next;
  logic signed [1:0] step_next;

  // take an entry when the output register is free or being emptied
  assign pop_ready = !out_valid || !out_stall;
  assign load      = pop_valid && pop_ready;

  // decode the command
  always_comb begin
    paused_next = paused;
    kill_next   = 1'b0;
    step_next   = 2'sd0;
    unique case (pop_entry.cmd)
      CMD_TOGGLE: paused_next = !paused;
      CMD_PREV: begin
        kill_next = 1'b1;
        step_next = -2'sd1;
      end
      CMD_BACK2: begin
        kill_next = 1'b1;
        step_next = -2'sd2;
      end
      CMD_STAY:  kill_next = 1'b1;
      default:   kill_next = 1'b0;
    endcase
  end

  // pause flag and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      paused    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        paused    <= paused_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      button_code  <= pop_entry.button;
      pressed      <= pop_entry.pressed;
      pause_flag   <= paused_next;
      kill_request <= kill_next;
      song_step    <= step_next;
    end
  end

  a_pause_only_toggle: assert property (@(posedge clk) disable iff (rst)
    (paused != $past(paused)) |-> $past(load && pop_entry.cmd == CMD_TOGGLE))
    else $error("pause flag changed without a toggle");

  a_step_needs_kill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kill_request) |-> song_step == 2'sd0)
    else $error("song step without kill request");

  a_kill_needs_press: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kill_request) |-> pressed)
    else $error("kill request from a release");

endmodule

// ----- src/button_packet_parser_unit.sv -----
// ----------------------------------------------------------------------------
// button_packet_parser_unit: button packet parser
// Finds five-byte button packets in a received byte stream and turns each
// good packet into one pause / track-control result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) takes one received byte per
//   item. Output channel (out_valid / out_stall and the result fields) gives
//   one item per packet whose check byte matches; other bytes give nothing.
//   Throughput is one byte per cycle while in_stall is low. The parser
//   classifies the packet when its check byte is taken and pushes it into a
//   small queue; the action stage pops it from the queue into the output
//   register once that register is free or being emptied, which raises
//   out_valid and holds the result there until it is taken.
//   Reset (rst, synchronous) returns the parser to hunting for '!', empties
//   the queue and clears the internal pause state to playing.
//   When the receiver stalls, the result stays in the output register, the
//   queue fills, and in_stall rises only once the queue is full.
// ----------------------------------------------------------------------------
module button_packet_parser_unit #(
  parameter int QUEUE_DEPTH = bpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        button_code,
  output logic              pressed,
  output logic              pause_flag,
  output logic              kill_request,
  output logic signed [1:0] song_step
);
  import bpp_pkg::*;

  logic       push_valid;
  logic       push_ready;
  logic       pop_valid;
  logic       pop_ready;
  bpp_entry_t push_entry;
  bpp_entry_t pop_entry;

  // parser
  bpp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue
  bpp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // action stage
  bpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .button_code  (button_code),
    .pressed      (pressed),
    .pause_flag   (pause_flag),
    .kill_request (kill_request),
    .song_step    (song_step)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for button_packet_parser_unit
// Feeds directed and random byte streams into the parser with random gaps on
// the input side and random stalls on the output side. A behavioral copy of
// the parser predicts each packet result, and every result the block gives
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import bpp_pkg::*;

  // one predicted packet result
  typedef struct packed {
    logic [7:0]        button_code;
    logic              pressed;
    logic              pause_flag;
    logic              kill_request;
    logic signed [1:0] song_step;
  } button_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        button_code;
  logic              pressed;
  logic              pause_flag;
  logic              kill_request;
  logic signed [1:0] song_step;

  // predictor state
  bpp_phase_t     parse_phase = PH_HUNT;
  logic [7:0]     pend_button = 8'h00;
  logic [7:0]     pend_hit = 8'h00;
  logic           pause_state = 1'b0;
  button_result_t pending_results[$];

  int fail_cnt = 0;
  int bytes_sent = 0;
  int stall_hold = 0;
  bit burst_mode = 1'b0;

  button_packet_parser_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .button_code  (button_code),
    .pressed      (pressed),
    .pause_flag   (pause_flag),
    .kill_request (kill_request),
    .song_step    (song_step)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL button_packet_parser_unit");
    $finish;
  end

  // check byte of a packet: low byte of the inverted sum of the first four
  function automatic logic [7:0] packet_check(input logic [7:0] btn, input logic [7:0] hit);
    logic [7:0] sum;
    sum = CH_START + CH_BUTTON + btn + hit;
    return ~sum;
  endfunction

  // mostly short gaps, a few long ones, none in burst mode
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // advance the parser copy by one accepted byte
  task automatic track_byte(input logic [7:0] b);
    button_result_t res;
    case (parse_phase)
      PH_START: begin
        parse_phase = (b == CH_BUTTON) ? PH_TYPE : PH_HUNT;
      end
      PH_TYPE: begin
        pend_button = b;
        parse_phase = PH_NUM;
      end
      PH_NUM: begin
        pend_hit = b;
        parse_phase = PH_HIT;
      end
      PH_HIT: begin
        parse_phase = PH_HUNT;
        if (b == packet_check(pend_button, pend_hit)) begin
          res.button_code = pend_button;
          res.pressed = (pend_hit == CH_ONE);
          res.kill_request = 1'b0;
          res.song_step = 2'sd0;
          if (res.pressed) begin
            if (pend_button == CH_ONE) begin
              pause_state = ~pause_state;
            end else if (pend_button == CH_TWO) begin
              res.kill_request = 1'b1;
              res.song_step = -2'sd1;
            end else if (pend_button == CH_THREE) begin
              res.kill_request = 1'b1;
              res.song_step = -2'sd2;
            end else if (pend_button == CH_FOUR) begin
              res.kill_request = 1'b1;
            end
          end
          res.pause_flag = pause_state;
          pending_results.push_back(res);
        end
      end
      default: begin
        parse_phase = (b == CH_START) ? PH_START : PH_HUNT;
      end
    endcase
  endtask

  // send one byte item; valid stays high across back-to-back items
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_byte <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] btn, input logic [7:0] hit, input bit good);
    logic [7:0] chk;
    chk = packet_check(btn, hit);
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    send_byte(CH_START);
    send_byte(CH_BUTTON);
    send_byte(btn);
    send_byte(hit);
    send_byte(chk);
  endtask

  // output stall: random on/off stretches, mostly short, off in burst mode once the current stretch ends
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (burst_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    button_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual button_code %h",
                 $time, button_code);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("button_code", want.button_code, button_code);
        check_field("pressed", 8'(want.pressed), 8'(pressed));
        check_field("pause_flag", 8'(want.pause_flag), 8'(pause_flag));
        check_field("kill_request", 8'(want.kill_request), 8'(kill_request));
        check_field("song_step", 8'(want.song_step), 8'(song_step));
      end
    end
  end

  // pause key pressed twice and released once
  task automatic test_pause_toggle();
    send_packet(CH_ONE, CH_ONE, 1'b1);
    send_packet(CH_ONE, 8'h30, 1'b1);
    send_packet(CH_ONE, CH_ONE, 1'b1);
  endtask

  // track keys, back to back
  task automatic test_track_keys();
    burst_mode = 1'b1;
    send_packet(CH_TWO, CH_ONE, 1'b1);
    send_packet(CH_THREE, CH_ONE, 1'b1);
    send_packet(CH_FOUR, CH_ONE, 1'b1);
    burst_mode = 1'b0;
  endtask

  // extreme button and hit bytes
  task automatic test_field_extremes();
    send_packet(8'hFF, 8'h00, 1'b1);
    send_packet(8'h00, 8'hFF, 1'b1);
  endtask

  // a second start byte in place of 'B' loses that packet, and a bad check byte is ignored
  task automatic test_broken_packets();
    send_byte(CH_START);
    send_packet(CH_TWO, CH_ONE, 1'b1);
    send_packet(CH_ONE, CH_ONE, 1'b0);
  endtask

  // mostly well-formed packets with random content, the rest broken or noise
  task automatic test_random_stream();
    int r;
    int n;
    logic [7:0] btn;
    logic [7:0] hit;
    while (bytes_sent < 800) begin
      if ($urandom_range(0, 49) == 0) burst_mode = ~burst_mode;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        btn = ($urandom_range(0, 1) == 0) ? 8'(CH_ONE + $urandom_range(0, 3)) : 8'($urandom);
        hit = ($urandom_range(0, 4) < 3) ? CH_ONE : 8'($urandom);
        send_packet(btn, hit, $urandom_range(0, 99) < 85);
      end else if (r < 80) begin
        send_byte(CH_START);
        send_byte(CH_BUTTON);
        n = $urandom_range(0, 2);
        repeat (n) send_byte(8'($urandom));
      end else if (r < 88) begin
        send_byte(CH_START);
        send_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom));
      end
    end
    burst_mode = 1'b0;
  endtask

  // main sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_pause_toggle();
    test_track_keys();
    test_field_extremes();
    test_broken_packets();
    test_random_stream();
    in_valid <= 1'b0;
    burst_mode = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS button_packet_parser_unit");
    end else begin
      $display("FAIL button_packet_parser_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/bpp_pkg.sv
src/bpp_front.sv
src/bpp_queue.sv
src/bpp_back.sv
src/button_packet_parser_unit.sv
tb/sv/tb_top.sv
